// ===== hdl/bpr_pkg.sv =====
// Shared types and constants for the Pascal-row binomial unit.
package bpr_pkg;

    localparam int ROW_W  = 12;
    localparam int COL_W  = 7;
    localparam int COEF_W = 64;

    // Value and saturation flag held by one cell of the row.
    typedef struct packed {
        logic [COEF_W-1:0] value;
        logic              sat;
    } t_cell_data;

    // Controls broadcast to every cell of the row (cell 0 takes the load only).
    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // Where the result word comes from once the row walk is done.
    typedef enum logic [1:0] {
        RES_CELL,
        RES_ZERO,
        RES_FULL
    } t_res;

endpackage

// ===== hdl/bpr_ifs.sv =====
// Valid/ready channel interfaces for the request and the result words.
interface bpr_req_if;
    logic                              valid;
    logic                              ready;
    logic [bpr_pkg::ROW_W-1:0]         row_n;
    logic signed [bpr_pkg::COL_W-1:0]  column_k;

    modport source (output valid, output row_n, output column_k, input ready);
    modport sink   (input valid, input row_n, input column_k, output ready);
endinterface

interface bpr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bpr_pkg::COEF_W-1:0]  coefficient;
    logic                        overflow;

    modport source (output valid, output coefficient, output overflow, input ready);
    modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

// ===== hdl/binomial_by_pascal_row_unit.sv =====
// Binomial coefficient unit: a row of adder cells walks Pascal's triangle one row per cycle.
// The row count is n after clamping to MAX_N; the result word is registered once it has counted down to zero.
// A new request is taken only once the last one is finished; the row of MAX_K+1 cells does one row per cycle.
// Special cases (negative k, k above n, k above MAX_K) finish without stepping the row.
// A finished result waits in an output register; the next request is taken meanwhile.
// Reset (synchronous, active low) returns control to idle and empties the output register.
module binomial_by_pascal_row_unit #(
    parameter int MAX_K = 63,
    parameter int MAX_N = 4095
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpr_req_if.sink    i_req,
    bpr_rsp_if.source  o_rsp
);

    localparam int NCELL = MAX_K + 1;
    localparam int KW    = (NCELL > 1) ? $clog2(NCELL) : 1;

    bpr_pkg::t_state r_state, n_state;
    logic [bpr_pkg::ROW_W-1:0]  r_cnt, n_cnt;
    logic [KW-1:0]              r_kidx, n_kidx;
    bpr_pkg::t_res              r_res, n_res;
    logic                       r_out_valid, n_out_valid;
    logic [bpr_pkg::COEF_W-1:0] r_coef, n_coef;
    logic                       r_ovf, n_ovf;

    logic                       w_accept;
    logic                       w_finish;
    logic [bpr_pkg::ROW_W-1:0]  w_n_eff;
    logic [5:0]                 w_k;
    logic                       w_zero;
    logic                       w_full;
    bpr_pkg::t_cell_ctrl        w_ctrl;
    bpr_pkg::t_cell_data        w_cell [NCELL];
    bpr_pkg::t_cell_data        w_pick;

    assign i_req.ready = (r_state == bpr_pkg::ST_IDLE);
    assign w_accept    = i_req.valid & i_req.ready;

    assign w_n_eff = ({20'b0, i_req.row_n} > 32'(MAX_N)) ? 12'(MAX_N) : i_req.row_n;
    assign w_k     = i_req.column_k[5:0];
    assign w_zero  = i_req.column_k[6] | ({6'b0, w_k} > w_n_eff);
    assign w_full  = ({26'b0, w_k} > 32'(MAX_K));

    assign w_ctrl.load = w_accept & ~w_zero & ~w_full;
    assign w_ctrl.step = (r_state == bpr_pkg::ST_RUN) & (r_cnt != '0);

    assign w_finish = (r_state == bpr_pkg::ST_RUN) & (r_cnt == '0)
                      & (~r_out_valid | o_rsp.ready);

    // Cell 0 is seeded with one and never steps; the rest start at zero.
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        bpr_pkg::t_cell_data w_seed;
        bpr_pkg::t_cell_data w_left;
        bpr_pkg::t_cell_ctrl w_cctrl;

        if (j == 0) begin : g_first
            assign w_seed  = '{value: 64'd1, sat: 1'b0};
            assign w_left  = '{value: '0, sat: 1'b0};
            assign w_cctrl = '{load: w_ctrl.load, step: 1'b0};
        end else begin : g_rest
            assign w_seed  = '{value: '0, sat: 1'b0};
            assign w_left  = w_cell[j-1];
            assign w_cctrl = w_ctrl;
        end

        bpr_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_cctrl),
            .i_seed (w_seed),
            .i_left (w_left),
            .o_cell (w_cell[j])
        );
    end

    assign w_pick = w_cell[r_kidx];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_kidx      = r_kidx;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_coef      = r_coef;
        n_ovf       = r_ovf;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            bpr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = bpr_pkg::ST_RUN;
                    n_kidx  = KW'(w_k);
                    priority if (w_zero) begin
                        n_res = bpr_pkg::RES_ZERO;
                        n_cnt = '0;
                    end else if (w_full) begin
                        n_res = bpr_pkg::RES_FULL;
                        n_cnt = '0;
                    end else begin
                        n_res = bpr_pkg::RES_CELL;
                        n_cnt = w_n_eff;
                    end
                end
            end
            bpr_pkg::ST_RUN: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - 12'd1;
                end else if (w_finish) begin
                    n_state     = bpr_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    unique case (r_res)
                        bpr_pkg::RES_ZERO: begin
                            n_coef = '0;
                            n_ovf  = 1'b0;
                        end
                        bpr_pkg::RES_FULL: begin
                            n_coef = '1;
                            n_ovf  = 1'b1;
                        end
                        default: begin
                            n_coef = w_pick.value;
                            n_ovf  = w_pick.sat;
                        end
                    endcase
                end
            end
            default: begin
                n_state = bpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cnt  <= n_cnt;
        r_kidx <= n_kidx;
        r_res  <= n_res;
        r_coef <= n_coef;
        r_ovf  <= n_ovf;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.coefficient = r_coef;
    assign o_rsp.overflow    = r_ovf;

endmodule

// ===== hdl/bpr_cell.sv =====
// One cell of the Pascal row: adds its left neighbor into itself with saturation.
module bpr_cell (
    input  logic                i_clk,
    input  bpr_pkg::t_cell_ctrl i_ctrl,
    input  bpr_pkg::t_cell_data i_seed,
    input  bpr_pkg::t_cell_data i_left,
    output bpr_pkg::t_cell_data o_cell
);

    bpr_pkg::t_cell_data r_cell;
    bpr_pkg::t_cell_data n_cell;
    logic [bpr_pkg::COEF_W:0] w_sum;
    logic                     w_sat;

    // A saturated addend keeps the sum pinned at all ones.
    assign w_sum = {1'b0, r_cell.value} + {1'b0, i_left.value};
    assign w_sat = r_cell.sat | i_left.sat | w_sum[bpr_pkg::COEF_W];

    always_comb begin
        n_cell = r_cell;
        if (i_ctrl.load) begin
            n_cell = i_seed;
        end else if (i_ctrl.step) begin
            n_cell.sat   = w_sat;
            n_cell.value = w_sat ? {bpr_pkg::COEF_W{1'b1}} : w_sum[bpr_pkg::COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

// ===== hdl/bpr_checker.sv =====
// Port-level checks for the Pascal-row binomial unit, bound to the top level.
module bpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_coefficient,
    input logic        i_overflow
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_coefficient)
        && $stable(i_overflow))
        else $error("result word changed while stalled");

    // Saturation always shows up as an all-ones coefficient.
    a_ovf_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |-> i_coefficient == 64'hFFFF_FFFF_FFFF_FFFF)
        else $error("overflow without all-ones coefficient");

    // Only one request is in work at a time.
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while another is in work");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind binomial_by_pascal_row_unit bpr_checker u_bpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_coefficient (o_rsp.coefficient),
    .i_overflow    (o_rsp.overflow)
);

// ===== dv/tb_bpr_checker.sv =====
// Checker for the Pascal-row binomial unit: predicts each result word and compares it.
module tb_bpr_checker #(
    parameter int MAX_K = 63,
    parameter int MAX_N = 4095
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bpr_req_if   req_mon,
    bpr_rsp_if   rsp_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_W       = bpr_pkg::ROW_W;
    localparam int COL_W       = bpr_pkg::COL_W;
    localparam int COEF_W      = bpr_pkg::COEF_W;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [COEF_W-1:0] coefficient;
        logic              overflow;
    } t_binom_word;

    t_binom_word binom_q[$];

    // Walks Pascal's triangle with saturating cells, the same way the row of adders does.
    function automatic t_binom_word predict_binomial(logic [ROW_W-1:0] row_n,
                                                     logic signed [COL_W-1:0] column_k);
        logic [COEF_W-1:0] cells [0:MAX_K];
        logic              sat_flags [0:MAX_K];
        logic [COEF_W:0]   sum;
        logic              sat;
        int                n;
        int                k;
        int                top;
        t_binom_word       res;

        n = int'(row_n);
        if (n > MAX_N) n = MAX_N;
        res.coefficient = '0;
        res.overflow    = 1'b0;
        if (column_k < 0) return res;
        k = int'(column_k);
        if (k > n) return res;
        if (k > MAX_K) begin
            res.coefficient = '1;
            res.overflow    = 1'b1;
            return res;
        end
        cells[0]     = COEF_W'(1);
        sat_flags[0] = 1'b0;
        for (int j = 1; j <= k; j++) begin
            cells[j]     = '0;
            sat_flags[j] = 1'b0;
        end
        for (int i = 1; i <= n; i++) begin
            top = (i < k) ? i : k;
            for (int j = top; j > 0; j--) begin
                sum = {1'b0, cells[j]} + {1'b0, cells[j-1]};
                // A saturated addend keeps the cell pinned even without a carry out.
                sat = sat_flags[j] | sat_flags[j-1] | sum[COEF_W];
                cells[j]     = sat ? '1 : sum[COEF_W-1:0];
                sat_flags[j] = sat;
            end
        end
        res.coefficient = cells[k];
        res.overflow    = sat_flags[k];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_binom_word want;
        if (i_rst_n) begin
            // A result word can never belong to the request taken on the same edge.
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (binom_q.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $display("%0t: unexpected result word coefficient=%h overflow=%b",
                                 $realtime, rsp_mon.coefficient, rsp_mon.overflow);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = binom_q.pop_front();
                    if (rsp_mon.coefficient !== want.coefficient ||
                        rsp_mon.overflow !== want.overflow) begin
                        if (o_fail_count < MAX_REPORTS)
                            $display("%0t: mismatch coefficient exp=%h act=%h %s=%b act=%b",
                                     $realtime, want.coefficient, rsp_mon.coefficient,
                                     "overflow exp", want.overflow, rsp_mon.overflow);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                binom_q.push_back(predict_binomial(req_mon.row_n, req_mon.column_k));
            o_pending = binom_q.size();
        end
    end

endmodule

// ===== dv/tb_binomial_by_pascal_row_unit.sv =====
// Testbench top for the Pascal-row binomial unit: stimulus, stall patterns and verdict.
module tb_binomial_by_pascal_row_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_W        = bpr_pkg::ROW_W;
    localparam int COL_W        = bpr_pkg::COL_W;
    localparam int MAX_K        = 63;
    localparam int MAX_N        = 4095;
    localparam int RANDOM_WORDS = 120;
    // Longest correct quiet stretch is one full row walk plus a receiver stall and a
    // sender gap; the limit is several times that.
    localparam int IDLE_LIMIT   = 40000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   burst_left;

    bpr_req_if req_ch ();
    bpr_rsp_if rsp_ch ();

    binomial_by_pascal_row_unit #(
        .MAX_K (MAX_K),
        .MAX_N (MAX_N)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    tb_bpr_checker #(
        .MAX_K (MAX_K),
        .MAX_N (MAX_N)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_binomial_by_pascal_row_unit NOT OK");
                $finish;
            end
        end
    end

    // Receiver: windows of full speed, scattered stalls, and long stalls.
    initial begin
        int mode;
        int window;
        int stall_left;
        rsp_ch.ready = 1'b0;
        mode       = 0;
        window     = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (window == 0) begin
                mode   = $urandom_range(0, 2);
                window = $urandom_range(50, 300);
            end
            window = window - 1;
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end else if (mode == 1) begin
                rsp_ch.ready <= 1'($urandom_range(0, 1));
            end else if (mode == 2 && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 11);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Sends one request word, opening a new burst after a random gap when the last one ran out.
    task automatic send_request(logic [ROW_W-1:0] row_n, logic signed [COL_W-1:0] column_k);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid    <= 1'b0;
                req_ch.row_n    <= ROW_W'($urandom);
                req_ch.column_k <= COL_W'($urandom);
            end
        end
        burst_left = burst_left - 1;
        @(negedge i_clk);
        req_ch.valid    <= 1'b1;
        req_ch.row_n    <= row_n;
        req_ch.column_k <= column_k;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int n;
        int lim;
        int sel;
        logic signed [COL_W-1:0] k;
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(0, MAX_N) : $urandom_range(0, 130);
        lim = (n < MAX_K) ? n : MAX_K;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            k = COL_W'(-int'($urandom_range(1, 64)));
        else if (sel == 1 && n < MAX_K)
            k = COL_W'($urandom_range(n + 1, MAX_K));
        else
            k = COL_W'($urandom_range(0, lim));
        send_request(ROW_W'(n), k);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.row_n    = '0;
        req_ch.column_k = '0;
        burst_left      = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Edges of both fields, the trivial rows, a negative column, a column past the
        // row, results on either side of the 64-bit limit, and saturated wide rows.
        send_request(12'd0, 7'sd0);
        send_request(12'd0, 7'sd1);
        send_request(12'd0, -7'sd1);
        send_request(12'd5, -7'sd64);
        send_request(12'd1, 7'sd0);
        send_request(12'd1, 7'sd1);
        send_request(12'd2, 7'sd1);
        send_request(12'd10, 7'sd11);
        send_request(12'd12, 7'sd63);
        send_request(12'd63, 7'sd63);
        send_request(12'd63, -7'sd1);
        send_request(12'd64, 7'sd32);
        send_request(12'd66, 7'sd33);
        send_request(12'd67, 7'sd33);
        send_request(12'd68, 7'sd34);
        send_request(12'd100, 7'sd50);
        send_request(12'd4095, 7'sd0);
        send_request(12'd4095, 7'sd1);
        send_request(12'd4095, 7'sd62);
        send_request(12'd4095, 7'sd63);
        send_request(12'd4095, -7'sd1);

        repeat (RANDOM_WORDS) send_random_request();

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (MAX_N + 16) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_binomial_by_pascal_row_unit OK");
        else
            $display("tb_binomial_by_pascal_row_unit NOT OK");
        $finish;
    end

endmodule
